// ===== design/wfba_pkg.sv =====
package wfba_pkg;

    // Default sizing of the partition table
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    // Fixed field widths of the item ports
    localparam int IDX_FW  = 4;
    localparam int SIZE_FW = 16;
    localparam int CNT_FW  = 5;

    // Item command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic               command;
        logic [IDX_FW-1:0]  block_index;
        logic [SIZE_FW-1:0] size;
    } t_req_item;

    typedef struct packed {
        logic               found;
        logic [IDX_FW-1:0]  chosen_block;
        logic [SIZE_FW-1:0] chosen_size;
        logic [SIZE_FW-1:0] leftover;
    } t_rsp_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic finish;
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_ctl_sts;

endpackage

// ===== design/worst_fit_block_allocator.sv =====
// Worst-fit partition allocator. A load item (command 0) writes one
// partition size and frees that partition; it is taken without leaving idle and
// gives no result. A request item (command 1) scans partitions
// 0 .. block_count-1 (capped at MAX_BLOCKS) and claims the free partition
// that leaves the most space, lowest index on a tie, returning found = 0 with
// zeroed fields if nothing fits. A request is accepted, then the scan reads
// one partition per step from the size memory through its single registered
// read port, then the scan is closed and the result register is loaded. The
// result register frees the output side, so a new item is taken while a result
// still waits; a request only holds in its finish step if the previous result
// is still stalled. Partition sizes wider than SIZE_WIDTH saturate.
// block_count may be written only while no request is in flight.
module worst_fit_block_allocator #(
    parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_WIDTH = wfba_pkg::SIZE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  wfba_pkg::t_req_item         i_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output wfba_pkg::t_rsp_item         o_item,
    input  logic                        i_cfg_we,
    input  logic [wfba_pkg::CNT_FW-1:0] i_cfg_wdata
);
    import wfba_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;

    wfba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_item.command),
        .o_stall   (o_stall),
        .i_sts     (ctl_sts),
        .o_cmd     (ctl_cmd)
    );

    wfba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_sts       (ctl_sts),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

endmodule

// ===== design/wfba_ctrl.sv =====
module wfba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    output logic              o_stall,
    input  wfba_pkg::t_ctl_sts i_sts,
    output wfba_pkg::t_ctl_cmd o_cmd
);
    import wfba_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Sequence one item at a time
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_command == CMD_ALLOC) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/wfba_datapath.sv =====
module wfba_datapath #(
    parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_WIDTH = wfba_pkg::SIZE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wfba_pkg::t_ctl_cmd            i_cmd,
    output wfba_pkg::t_ctl_sts            o_sts,
    input  wfba_pkg::t_req_item           i_item,
    input  logic                          i_cfg_we,
    input  logic [wfba_pkg::CNT_FW-1:0]   i_cfg_wdata,
    output logic                          o_valid,
    input  logic                          i_stall,
    output wfba_pkg::t_rsp_item           o_item
);
    import wfba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [32:0] SIZE_LIM = (33'd1 << SIZE_WIDTH) - 33'd1;

    logic [CNT_FW-1:0]     r_block_count;
    logic [SIZE_WIDTH-1:0] r_mem [MAX_BLOCKS];
    logic [SIZE_WIDTH-1:0] r_rd_data;
    logic [MAX_BLOCKS-1:0] r_taken;
    logic [SIZE_WIDTH-1:0] r_req;
    logic [CNT_W-1:0]      r_j;
    logic [CNT_W-1:0]      r_n;
    logic                  r_cmp_valid;
    logic                  r_cmp_taken;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_best;
    logic [SIZE_WIDTH-1:0] r_best_size;
    logic [SIZE_WIDTH-1:0] r_best_left;
    logic                  r_out_valid;
    t_rsp_item             r_out;

    logic [SIZE_WIDTH-1:0] sat_size;
    logic [CNT_W-1:0]      n_lim;
    logic [IDX_W-1:0]      scan_addr;
    logic [IDX_W-1:0]      load_addr;
    logic                  load_ok;
    logic                  fits;
    logic [SIZE_WIDTH-1:0] left;
    logic                  better;
    logic                  out_free;

    // Saturate the incoming size and cap the scan length
    always_comb begin
        if (33'(i_item.size) > SIZE_LIM) begin
            sat_size = SIZE_WIDTH'(SIZE_LIM);
        end else begin
            sat_size = SIZE_WIDTH'(i_item.size);
        end
        if (32'(r_block_count) > 32'(MAX_BLOCKS)) begin
            n_lim = CNT_W'(MAX_BLOCKS);
        end else begin
            n_lim = CNT_W'(r_block_count);
        end
    end

    assign scan_addr = r_j[IDX_W-1:0];
    assign load_addr = IDX_W'(i_item.block_index);
    assign load_ok   = 32'(i_item.block_index) < 32'(MAX_BLOCKS);

    // Compare the partition read last cycle against the best so far
    assign fits   = r_cmp_valid && !r_cmp_taken && (r_rd_data >= r_req);
    assign left   = r_rd_data - r_req;
    assign better = fits && (!r_hit || (left > r_best_left));

    assign out_free        = !r_out_valid || !i_stall;
    assign o_sts.scan_done = (r_j == r_n);
    assign o_sts.out_free  = out_free;

    // Hold the block count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= '0;
        end else if (i_cfg_we) begin
            r_block_count <= i_cfg_wdata;
        end
    end

    // Write sizes on load, read one partition per scan step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            r_mem[load_addr] <= sat_size;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[scan_addr];
        end
    end

    // Clear taken flags on load, set the chosen one on finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else if (i_cmd.load && load_ok) begin
            r_taken[load_addr] <= 1'b0;
        end else if (i_cmd.finish && r_hit) begin
            r_taken[r_best] <= 1'b1;
        end
    end

    // Advance the scan and track the best fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_j         <= '0;
            r_n         <= '0;
        end else begin
            r_cmp_valid <= i_cmd.issue;
            if (i_cmd.start) begin
                r_req <= sat_size;
                r_n   <= n_lim;
                r_j   <= '0;
                r_hit <= 1'b0;
            end
            if (i_cmd.issue) begin
                r_j         <= r_j + 1'b1;
                r_cmp_idx   <= scan_addr;
                r_cmp_taken <= r_taken[scan_addr];
            end
            if (better) begin
                r_hit       <= 1'b1;
                r_best      <= r_cmp_idx;
                r_best_size <= r_rd_data;
                r_best_left <= left;
            end
        end
    end

    // Load the result register and drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.found <= r_hit;
            if (r_hit) begin
                r_out.chosen_block <= IDX_FW'(r_best);
                r_out.chosen_size  <= SIZE_FW'(r_best_size);
                r_out.leftover     <= SIZE_FW'(r_best_left);
            end else begin
                r_out.chosen_block <= '0;
                r_out.chosen_size  <= '0;
                r_out.leftover     <= '0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
